/* rtl/core/rau_pkg.sv */
// Package for the rational arithmetic unit.
// Holds operation and status codes, the job word passed front to back, and
// the state types. No dependencies.
package rau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // One classified job: divide-by-zero flag, sign, unreduced magnitude and denominator
  typedef struct packed {
    logic        div0;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] den;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL0, F_MUL1, F_MUL2, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_GCD, B_DIV, B_FIX, B_DONE
  } back_state_t;

endpackage

/* rtl/core/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: front end, job queue, back end.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
//
//   channel | handshake           | words
//   in      | in_valid / in_stall | operation, left/right numerator+denominator
//   out     | out_valid/out_stall | result_numerator, result_denominator, status
//
// Front end forms three products per word on one multiplier, then pushes the job.
// Back end runs a binary GCD, then bit-serial division of both values;
// zero and error results skip both.
// Two queued jobs let the front end keep accepting while a result is stalled.
// Reset is synchronous and clears all control state.
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] left_numerator,
  input  logic [30:0] left_denominator,
  input  logic [31:0] right_numerator,
  input  logic [30:0] right_denominator,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_numerator,
  output logic [30:0] result_denominator,
  output logic [1:0]  status
);
  import rau_pkg::*;

  job_t fj, qj;
  logic fvalid, qfull, qempty, qpop;

  rau_front u_front (
    .clk, .rst, .in_valid, .in_stall, .operation,
    .left_numerator, .left_denominator, .right_numerator, .right_denominator,
    .job_valid(fvalid), .job_full(qfull), .job(fj)
  );

  rau_queue u_queue (
    .clk, .rst, .push(fvalid), .push_job(fj), .full(qfull),
    .pop(qpop), .empty(qempty), .pop_job(qj)
  );

  rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst, .job_empty(qempty), .job(qj), .job_pop(qpop),
    .out_valid, .out_stall, .result_numerator, .result_denominator, .status
  );

endmodule

/* rtl/core/rau_front.sv */
// Front end: accepts an operand word, forms the cross products on one shared
// 32x32 multiplier and pushes a classified job. Depends on rau_pkg.
module rau_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       operation,
  input  logic [31:0]      left_numerator,
  input  logic [30:0]      left_denominator,
  input  logic [31:0]      right_numerator,
  input  logic [30:0]      right_denominator,
  output logic             job_valid,
  input  logic             job_full,
  output rau_pkg::job_t    job
);
  import rau_pkg::*;

  front_state_t state, state_next;
  logic [1:0]   op;
  logic         lneg, rneg;
  logic [31:0]  lmag, rmag;
  logic [30:0]  ld, rd;
  logic [63:0]  p0, p1, p2;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  product;
  logic         bneg;
  logic         same;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_valid) state_next = F_MUL0;
      F_MUL0: state_next = F_MUL1;
      F_MUL1: state_next = F_MUL2;
      F_MUL2: state_next = F_PUSH;
      F_PUSH: if (!job_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall  = (state != F_IDLE);
    job_valid = (state == F_PUSH);
  end

  // Multiplier operand select per step
  always_comb begin
    unique case (state)
      F_MUL0: begin
        mul_a = lmag;
        mul_b = (op == OP_MUL) ? rmag : {1'b0, rd};
      end
      F_MUL1: begin
        mul_a = rmag;
        mul_b = {1'b0, ld};
      end
      default: begin
        mul_a = {1'b0, ld};
        mul_b = (op == OP_DIV) ? rmag : {1'b0, rd};
      end
    endcase
    product = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == F_IDLE && in_valid) begin
      op   <= operation;
      lneg <= left_numerator[31];
      rneg <= right_numerator[31];
      lmag <= left_numerator[31] ? (32'd0 - left_numerator) : left_numerator;
      rmag <= right_numerator[31] ? (32'd0 - right_numerator) : right_numerator;
      ld   <= left_denominator;
      rd   <= right_denominator;
    end
    if (state == F_MUL0) p0 <= product;
    if (state == F_MUL1) p1 <= product;
    if (state == F_MUL2) p2 <= product;
  end

  // Combine products into a signed magnitude
  always_comb begin
    bneg     = (op == OP_SUB) ? !rneg : rneg;
    same     = (lneg == bneg);
    job.den  = p2;
    job.div0 = (ld == 31'd0) || (rd == 31'd0) || (op == OP_DIV && rmag == 32'd0);
    if (op == OP_ADD || op == OP_SUB) begin
      if (same) begin
        job.mag = p0 + p1;
        job.neg = lneg;
      end else if (p0 >= p1) begin
        job.mag = p0 - p1;
        job.neg = lneg;
      end else begin
        job.mag = p1 - p0;
        job.neg = bneg;
      end
    end else begin
      job.mag = p0;
      job.neg = lneg ^ rneg;
    end
  end

endmodule

/* rtl/core/rau_queue.sv */
// Two-entry job queue between front and back end.
// Depends on rau_pkg for the job word.
module rau_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rau_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rau_pkg::job_t pop_job
);
  import rau_pkg::*;

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= !wr_ptr;
      if (pop && !empty) rd_ptr <= !rd_ptr;
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
    if (push && !full) slots[wr_ptr] <= push_job;
  end

endmodule

/* rtl/core/rau_back.sv */
// Back end: binary GCD, two bit-serial exact divisions, range check and
// the result register. Depends on rau_pkg.
module rau_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_empty,
  input  rau_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   result_numerator,
  output logic [30:0]   result_denominator,
  output logic [1:0]    status
);
  import rau_pkg::*;

  localparam logic [63:0] LIMIT = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  back_state_t state, state_next;
  logic        neg;
  logic [63:0] ga, gb, g;
  logic [5:0]  shift;
  logic [5:0]  cnt;
  logic [63:0] q0, q1, r0, r1;
  logic [64:0] t0, t1;
  logic        early;
  logic [1:0]  early_st;

  assign early = job.div0 || (job.mag == 64'd0);
  assign early_st = job.div0 ? ST_DIV0 : ST_OK;
  assign t0 = {r0, q0[63]};
  assign t1 = {r1, q1[63]};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!job_empty) state_next = early ? B_DONE : B_GCD;
      B_GCD:  if (ga == gb) state_next = B_DIV;
      B_DIV:  if (cnt == 6'd63) state_next = B_FIX;
      B_FIX:  state_next = B_DONE;
      B_DONE: if (!out_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    job_pop   = (state == B_IDLE) && !job_empty;
    out_valid = (state == B_DONE);
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
    unique case (state)
      B_IDLE: begin
        ga    <= job.mag;
        gb    <= job.den;
        q0    <= job.mag;
        q1    <= job.den;
        neg   <= job.neg;
        shift <= 6'd0;
        result_numerator   <= 32'd0;
        result_denominator <= 31'd1;
        status             <= early_st;
      end
      // One Stein step per cycle; both operands stay nonzero
      B_GCD: begin
        if (ga == gb) begin
          g   <= ga << shift;
          cnt <= 6'd0;
          r0  <= 64'd0;
          r1  <= 64'd0;
        end else if (!ga[0] && !gb[0]) begin
          ga    <= ga >> 1;
          gb    <= gb >> 1;
          shift <= shift + 6'd1;
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga > gb) begin
          ga <= ga - gb;
        end else begin
          gb <= gb - ga;
        end
      end
      // Restoring division of both values by the gcd, one bit a cycle
      B_DIV: begin
        cnt <= cnt + 6'd1;
        if (t0 >= {1'b0, g}) begin
          r0 <= 64'(t0 - {1'b0, g});
          q0 <= {q0[62:0], 1'b1};
        end else begin
          r0 <= t0[63:0];
          q0 <= {q0[62:0], 1'b0};
        end
        if (t1 >= {1'b0, g}) begin
          r1 <= 64'(t1 - {1'b0, g});
          q1 <= {q1[62:0], 1'b1};
        end else begin
          r1 <= t1[63:0];
          q1 <= {q1[62:0], 1'b0};
        end
      end
      B_FIX: begin
        if (q0 > LIMIT || q1 > LIMIT) begin
          status <= ST_OVF;
        end else begin
          status             <= ST_OK;
          result_numerator   <= neg ? (32'd0 - q0[31:0]) : q0[31:0];
          result_denominator <= q1[30:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
